[design/ljpf_pkg.sv]
// Package: shared widths, constants, register codes and pipeline types of the pair force core.
package ljpf_pkg;

    localparam int POS_W      = 24;               // position width
    localparam int FRAC_W     = 16;               // fraction bits of positions and results
    localparam int DIFF_W     = POS_W + 1;        // signed coordinate difference
    localparam int MAG_W      = POS_W;            // minimum-image magnitude (below 2^POS_W)
    localparam int R2_W       = 2 * POS_W + 2;    // squared distance: sum of three squares
    localparam int Q_W        = 37;               // reciprocal width: r2 >= 2^28 keeps 1/r2 <= 2^36
    localparam int WORD_W     = 32;               // result word width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_W      = 64;               // operand width of the split multiplier

    localparam logic [R2_W-1:0] R2_MIN   = R2_W'(1) << (2 * FRAC_W - 4);
    localparam logic [R2_W-1:0] REM_INIT = R2_W'(1) << (2 * FRAC_W + 32 - Q_W);

    localparam logic [44:0] ONE_Q32    = 45'd1 << 32;
    localparam logic [45:0] ONE_Q32_W  = 46'd1 << 32;
    localparam logic [48:0] GABS_CAP   = 49'd1 << 48;

    localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

    localparam logic [23:0]        BOX_RESET      = 24'd1310720;
    localparam logic [29:0]        CUTOFF_RESET   = 30'd409600;
    localparam logic [23:0]        STRENGTH_RESET = 24'd327680;
    localparam logic signed [31:0] PSHIFT_RESET   = -32'sd5347;
    localparam logic signed [31:0] GSHIFT_RESET   = 32'sd5112;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_LENGTH      = 3'd0,
        REG_CUTOFF_SQUARED  = 3'd1,
        REG_STRENGTH        = 3'd2,
        REG_POTENTIAL_SHIFT = 3'd3,
        REG_GRADIENT_SHIFT  = 3'd4
    } cfg_reg_t;

    // Control and per-pair data that travels alongside the arithmetic.
    typedef struct packed {
        logic                  valid;
        logic                  in_cut;
        logic                  sat;
        logic                  negp;
        logic                  negg;
        logic [2:0]            dneg;
        logic [2:0][MAG_W-1:0] dmag;
    } side_t;

endpackage

[design/ljpf_ifs.sv]
// Interfaces: pair word input channel and result word output channel.
interface ljpf_pair_if;
    logic                      valid;
    logic                      ready;
    logic [ljpf_pkg::POS_W-1:0] first_x;
    logic [ljpf_pkg::POS_W-1:0] first_y;
    logic [ljpf_pkg::POS_W-1:0] first_z;
    logic [ljpf_pkg::POS_W-1:0] second_x;
    logic [ljpf_pkg::POS_W-1:0] second_y;
    logic [ljpf_pkg::POS_W-1:0] second_z;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  output ready);
endinterface

interface ljpf_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [ljpf_pkg::WORD_W-1:0] pair_potential;
    logic signed [ljpf_pkg::WORD_W-1:0] force_x;
    logic signed [ljpf_pkg::WORD_W-1:0] force_y;
    logic signed [ljpf_pkg::WORD_W-1:0] force_z;
    logic                              within_cutoff;
    logic                              saturated;

    modport source (output valid, pair_potential, force_x, force_y, force_z, within_cutoff,
                    saturated, input ready);
    modport sink (input valid, pair_potential, force_x, force_y, force_z, within_cutoff,
                  saturated, output ready);
endinterface

[design/ljpf_mul.sv]
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module ljpf_mul (
    input  logic                            clk,
    input  logic                            en,
    input  logic [ljpf_pkg::MUL_W-1:0]      a,
    input  logic [ljpf_pkg::MUL_W-1:0]      b,
    output logic [2*ljpf_pkg::MUL_W-1:0]    p
);
    import ljpf_pkg::*;

    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[31:0]  * b[31:0];
            lh_reg <= a[31:0]  * b[63:32];
            hl_reg <= a[63:32] * b[31:0];
            hh_reg <= a[63:32] * b[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p <= 128'(ll_reg) + (128'(lh_reg) << 32) + (128'(hl_reg) << 32)
                 + (128'(hh_reg) << 64);
        end
    end

endmodule

[design/ljpf_recip.sv]
// Pipelined restoring divider: floor(2^64 / r2), one quotient bit per stage.
module ljpf_recip (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [ljpf_pkg::R2_W-1:0]    r2,
    input  ljpf_pkg::side_t              side_in,
    output logic [ljpf_pkg::Q_W-1:0]     u,
    output ljpf_pkg::side_t              side_out
);
    import ljpf_pkg::*;

    logic [R2_W-1:0] rem_reg  [1:Q_W-1];
    logic [R2_W-1:0] den_reg  [1:Q_W-1];
    logic [Q_W-1:0]  q_reg    [1:Q_W];
    side_t           side_reg [1:Q_W];

    logic [R2_W-1:0] rem_cur  [0:Q_W-1];
    logic [R2_W-1:0] den_cur  [0:Q_W-1];
    logic [Q_W-1:0]  q_cur    [0:Q_W-1];
    side_t           side_cur [0:Q_W-1];
    logic [R2_W-1:0] rem_next [0:Q_W-1];
    logic [Q_W-1:0]  q_next   [0:Q_W-1];

    always_comb
    begin
        rem_cur[0]  = REM_INIT;
        den_cur[0]  = r2;
        q_cur[0]    = '0;
        side_cur[0] = side_in;
        for (int k = 1; k < Q_W; k++)
        begin
            rem_cur[k]  = rem_reg[k];
            den_cur[k]  = den_reg[k];
            q_cur[k]    = q_reg[k];
            side_cur[k] = side_reg[k];
        end
    end

    // One trial subtract per stage.
    always_comb
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            if ({rem_cur[k], 1'b0} >= {1'b0, den_cur[k]})
            begin
                rem_next[k] = R2_W'({rem_cur[k], 1'b0} - {1'b0, den_cur[k]});
                q_next[k]   = {q_cur[k][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = {rem_cur[k][R2_W-2:0], 1'b0};
                q_next[k]   = {q_cur[k][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k < Q_W; k++)
            begin
                rem_reg[k] <= rem_next[k-1];
                den_reg[k] <= den_cur[k-1];
            end
            for (int k = 1; k <= Q_W; k++)
                q_reg[k] <= q_next[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= Q_W; k++)
                side_reg[k] <= '0;
        end
        else if (en)
        begin
            for (int k = 1; k <= Q_W; k++)
                side_reg[k] <= side_cur[k-1];
        end
    end

    assign u        = q_reg[Q_W];
    assign side_out = side_reg[Q_W];

endmodule

[design/lennard_jones_pair_force_core.sv]
// Top level: shifted-force Lennard-Jones pair force pipeline with configuration registers.
//
// Takes one particle pair word per cycle, unless held (see below), and offers one result word
// per pair, in order, after 57 register stages, the first loaded at the accepting edge. The
// pipeline is fully streamed: five stages form the minimum-image vector and squared distance,
// a 37-stage restoring divider forms 1/r2 one quotient bit per stage, and fifteen stages, mostly
// split 64x64 multipliers, build the power terms, potential, gradient and per-axis forces.
// Throughput is one pair per cycle; while a finished result word waits on result.ready the
// whole pipeline holds, and pair_in.ready drops for exactly those cycles. Configuration
// registers (box length, squared cutoff, strength and the two shifts) are written through
// cfg_we/cfg_index/cfg_data and must only change while no pair is in flight. All values are
// Q8.16 in, Q15.16 out; pairs beyond the cutoff return all zeros.
module lennard_jones_pair_force_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ljpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ljpf_pkg::CFG_DATA_W-1:0]    cfg_data,
    ljpf_pair_if.sink                          pair_in,
    ljpf_result_if.source                      result
);
    import ljpf_pkg::*;

    // ---------------------------------------------------------------- configuration
    logic [23:0]        box_reg;
    logic [29:0]        cutoff_reg;
    logic [23:0]        strength_reg;
    logic signed [31:0] pshift_reg;
    logic signed [31:0] gshift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg      <= BOX_RESET;
            cutoff_reg   <= CUTOFF_RESET;
            strength_reg <= STRENGTH_RESET;
            pshift_reg   <= PSHIFT_RESET;
            gshift_reg   <= GSHIFT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOX_LENGTH:      box_reg      <= cfg_data[23:0];
                REG_CUTOFF_SQUARED:  cutoff_reg   <= cfg_data[29:0];
                REG_STRENGTH:        strength_reg <= cfg_data[23:0];
                REG_POTENTIAL_SHIFT: pshift_reg   <= signed'(cfg_data);
                REG_GRADIENT_SHIFT:  gshift_reg   <= signed'(cfg_data);
                default:             ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    // Hold every stage while the last stage has a word the sink has not taken.
    side_t side_pipe_reg [1:15];
    logic  pipe_en;

    assign pipe_en       = !(side_pipe_reg[15].valid && !result.ready);
    assign pair_in.ready = pipe_en;

    // ---------------------------------------------------------------- stage 1: differences
    logic [POS_W-1:0]         pos_a [3];
    logic [POS_W-1:0]         pos_b [3];
    logic                     p1_valid_reg;
    logic signed [DIFF_W-1:0] p1_diff_reg [3];

    assign pos_a[0] = pair_in.first_x;
    assign pos_a[1] = pair_in.first_y;
    assign pos_a[2] = pair_in.first_z;
    assign pos_b[0] = pair_in.second_x;
    assign pos_b[1] = pair_in.second_y;
    assign pos_b[2] = pair_in.second_z;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
                p1_diff_reg[i] <= signed'({1'b0, pos_b[i]}) - signed'({1'b0, pos_a[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (pipe_en)
            p1_valid_reg <= pair_in.valid;
    end

    // ---------------------------------------------------------------- stage 2: minimum image
    logic signed [DIFF_W:0] d_ext  [3];
    logic signed [DIFF_W:0] d_twice[3];
    logic signed [DIFF_W:0] d_img  [3];
    logic signed [DIFF_W:0] box_s;
    side_t                  p2_side_next;
    side_t                  p2_side_reg;

    assign box_s = signed'({2'b00, box_reg});

    // Fold once by a whole box; a tie at half a box flips sign.
    always_comb
    begin
        p2_side_next       = '0;
        p2_side_next.valid = p1_valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            d_ext[i]   = (DIFF_W + 1)'(p1_diff_reg[i]);
            d_twice[i] = signed'({p1_diff_reg[i], 1'b0});
            if (d_twice[i] >= box_s)
                d_img[i] = d_ext[i] - box_s;
            else if (d_twice[i] <= -box_s)
                d_img[i] = d_ext[i] + box_s;
            else
                d_img[i] = d_ext[i];
            p2_side_next.dneg[i] = d_img[i][DIFF_W];
            p2_side_next.dmag[i] = d_img[i][DIFF_W] ? MAG_W'(-d_img[i]) : d_img[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_side_reg <= '0;
        else if (pipe_en)
            p2_side_reg <= p2_side_next;
    end

    // ---------------------------------------------------------------- stage 3: squares
    logic [R2_W-1:0] p3_sq_reg [3];
    side_t           p3_side_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
                p3_sq_reg[i] <= p2_side_reg.dmag[i] * p2_side_reg.dmag[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_side_reg <= '0;
        else if (pipe_en)
            p3_side_reg <= p2_side_reg;
    end

    // ---------------------------------------------------------------- stage 4: r2
    logic [R2_W-1:0] p4_r2_reg;
    side_t           p4_side_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            p4_r2_reg <= p3_sq_reg[0] + p3_sq_reg[1] + p3_sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_side_reg <= '0;
        else if (pipe_en)
            p4_side_reg <= p3_side_reg;
    end

    // ---------------------------------------------------------------- stage 5: cutoff, clamp
    logic [R2_W-1:0] p5_r2c_reg;
    side_t           p5_side_next;
    side_t           p5_side_reg;
    logic            r2_close;

    assign r2_close = p4_r2_reg < R2_MIN;

    always_comb
    begin
        p5_side_next        = p4_side_reg;
        p5_side_next.in_cut = p4_r2_reg <= R2_W'({cutoff_reg, 16'd0});
        p5_side_next.sat    = r2_close;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            p5_r2c_reg <= r2_close ? R2_MIN : p4_r2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_side_reg <= '0;
        else if (pipe_en)
            p5_side_reg <= p5_side_next;
    end

    // ---------------------------------------------------------------- reciprocal
    logic [Q_W-1:0] u_q;
    side_t          div_side;

    ljpf_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .r2       (p5_r2c_reg),
        .side_in  (p5_side_reg),
        .u        (u_q),
        .side_out (div_side)
    );

    // ---------------------------------------------------------------- power terms
    logic [Q_W-1:0]   u_d1_reg, u_d2_reg;
    logic [127:0]     p_uu, p_u2u, p_u2u2, p_sdev, p_udev, p_pstr, p_gstr;
    logic [40:0]      u2;
    logic [44:0]      s4;
    logic [48:0]      u4;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            u_d1_reg <= u_q;
            u_d2_reg <= u_d1_reg;
        end
    end

    ljpf_mul u_mul_uu (.clk(clk), .en(pipe_en), .a(MUL_W'(u_q)), .b(MUL_W'(u_q)), .p(p_uu));

    assign u2 = p_uu[72:32];

    ljpf_mul u_mul_s (.clk(clk), .en(pipe_en), .a(MUL_W'(u2)), .b(MUL_W'(u_d2_reg)),
                      .p(p_u2u));
    ljpf_mul u_mul_u4 (.clk(clk), .en(pipe_en), .a(MUL_W'(u2)), .b(MUL_W'(u2)), .p(p_u2u2));

    assign s4 = p_u2u[76:32];
    assign u4 = p_u2u2[80:32];

    // Deviations (s - 1) and (1 - 2s) as magnitude and sign.
    logic [44:0] s5_reg, devp5_reg, devp_next;
    logic [48:0] u45_reg;
    logic [45:0] devg5_reg, devg_next, s4_twice;
    logic        negp_next, negg_next;

    assign s4_twice  = {s4, 1'b0};
    assign negp_next = s4 < ONE_Q32;
    assign devp_next = negp_next ? ONE_Q32 - s4 : s4 - ONE_Q32;
    assign negg_next = s4_twice > ONE_Q32_W;
    assign devg_next = negg_next ? s4_twice - ONE_Q32_W : ONE_Q32_W - s4_twice;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s5_reg    <= s4;
            devp5_reg <= devp_next;
            u45_reg   <= u4;
            devg5_reg <= devg_next;
        end
    end

    ljpf_mul u_mul_sdev (.clk(clk), .en(pipe_en), .a(MUL_W'(s5_reg)), .b(MUL_W'(devp5_reg)),
                         .p(p_sdev));
    ljpf_mul u_mul_udev (.clk(clk), .en(pipe_en), .a(MUL_W'(u45_reg)), .b(MUL_W'(devg5_reg)),
                         .p(p_udev));

    ljpf_mul u_mul_pstr (.clk(clk), .en(pipe_en), .a(MUL_W'(p_sdev[88:32])),
                         .b(MUL_W'(strength_reg)), .p(p_pstr));
    ljpf_mul u_mul_gstr (.clk(clk), .en(pipe_en), .a(MUL_W'(p_udev[93:32])),
                         .b(MUL_W'(strength_reg)), .p(p_gstr));

    // ---------------------------------------------------------------- scale and shift
    logic [50:0]        pmag10_reg;
    logic [58:0]        gmag10_reg;
    logic [53:0]        gm2;
    logic signed [63:0] pot11_reg, grad11_reg;
    logic signed [63:0] pmag_s, gmag_s;

    assign gm2 = p_gstr[85:32];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pmag10_reg <= {p_pstr[80:32], 2'b00};
            gmag10_reg <= 59'({gm2, 4'd0}) + 59'({gm2, 3'd0});
        end
    end

    assign pmag_s = signed'(64'(pmag10_reg));
    assign gmag_s = signed'(64'(gmag10_reg));

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pot11_reg  <= (side_pipe_reg[10].negp ? -pmag_s : pmag_s) - 64'(pshift_reg);
            grad11_reg <= (side_pipe_reg[10].negg ? -gmag_s : gmag_s) - 64'(gshift_reg);
        end
    end

    // ---------------------------------------------------------------- potential word, |G|
    logic [WORD_W-1:0] pot12_next;
    logic              pot_sat12;
    logic [63:0]       gabs_full;
    logic [48:0]       gabs12_reg;
    logic [WORD_W-1:0] pot12_reg, pot13_reg, pot14_reg, pot15_reg;

    always_comb
    begin
        pot_sat12  = 1'b0;
        pot12_next = pot11_reg[WORD_W-1:0];
        if (pot11_reg > WORD_MAX)
        begin
            pot12_next = 32'h7FFF_FFFF;
            pot_sat12  = 1'b1;
        end
        else if (pot11_reg < WORD_MIN)
        begin
            pot12_next = 32'h8000_0000;
            pot_sat12  = 1'b1;
        end
    end

    // A gradient at or above 2^48 saturates any nonzero force component anyway; cap it there.
    assign gabs_full = grad11_reg[63] ? 64'(-grad11_reg) : 64'(grad11_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            gabs12_reg <= (gabs_full > 64'(GABS_CAP)) ? GABS_CAP : gabs_full[48:0];
            pot12_reg  <= pot12_next;
            pot13_reg  <= pot12_reg;
            pot14_reg  <= pot13_reg;
            pot15_reg  <= pot14_reg;
        end
    end

    // ---------------------------------------------------------------- forces
    logic [127:0]      p_force [3];
    logic [56:0]       fm      [3];
    logic [56:0]       fm_neg  [3];
    logic [WORD_W-1:0] force_next  [3];
    logic [WORD_W-1:0] force15_reg [3];
    logic [2:0]        force_sat15;
    logic              fneg;

    for (genvar i = 0; i < 3; i++)
    begin : g_force
        ljpf_mul u_mul_force (
            .clk (clk),
            .en  (pipe_en),
            .a   (MUL_W'(gabs12_reg)),
            .b   (MUL_W'(side_pipe_reg[12].dmag[i])),
            .p   (p_force[i])
        );
    end

    always_comb
    begin
        fneg = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            fm[i]          = p_force[i][72:16];
            fm_neg[i]      = 57'd0 - fm[i];
            fneg           = side_pipe_reg[14].negg ^ side_pipe_reg[14].dneg[i];
            force_sat15[i] = 1'b0;
            if (fneg)
            begin
                if (fm[i] > 57'h8000_0000)
                begin
                    force_next[i]  = 32'h8000_0000;
                    force_sat15[i] = 1'b1;
                end
                else
                    force_next[i] = fm_neg[i][WORD_W-1:0];
            end
            else
            begin
                if (fm[i] > 57'h7FFF_FFFF)
                begin
                    force_next[i]  = 32'h7FFF_FFFF;
                    force_sat15[i] = 1'b1;
                end
                else
                    force_next[i] = fm[i][WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
                force15_reg[i] <= force_next[i];
        end
    end

    // ---------------------------------------------------------------- side channel
    // Advance flags with the data; update signs and saturation where they are formed.
    side_t side_next [1:15];

    always_comb
    begin
        side_next[1] = div_side;
        for (int k = 2; k <= 15; k++)
            side_next[k] = side_pipe_reg[k-1];
        side_next[5].negp  = negp_next;
        side_next[5].negg  = negg_next;
        side_next[12].negg = grad11_reg[63];
        side_next[12].sat  = side_pipe_reg[11].sat | pot_sat12;
        side_next[15].sat  = side_pipe_reg[14].sat | (|force_sat15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 15; k++)
                side_pipe_reg[k] <= '0;
        end
        else if (pipe_en)
        begin
            for (int k = 1; k <= 15; k++)
                side_pipe_reg[k] <= side_next[k];
        end
    end

    // ---------------------------------------------------------------- result word
    // Zero the potential, forces and saturated flag for pairs beyond the cutoff.
    assign result.valid          = side_pipe_reg[15].valid;
    assign result.within_cutoff  = side_pipe_reg[15].in_cut;
    assign result.saturated      = side_pipe_reg[15].in_cut & side_pipe_reg[15].sat;
    assign result.pair_potential = side_pipe_reg[15].in_cut ? signed'(pot15_reg) : '0;
    assign result.force_x        = side_pipe_reg[15].in_cut ? signed'(force15_reg[0]) : '0;
    assign result.force_y        = side_pipe_reg[15].in_cut ? signed'(force15_reg[1]) : '0;
    assign result.force_z        = side_pipe_reg[15].in_cut ? signed'(force15_reg[2]) : '0;

    // ---------------------------------------------------------------- assertions
    a_recip_range: assert property (@(posedge clk) disable iff (!rst_n)
        (div_side.valid && div_side.in_cut) |->
            (u_q > 37'd262144) && (u_q <= 37'd68719476736))
        else $error("reciprocal out of range for an in-cutoff pair");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.within_cutoff) |->
            (result.pair_potential == 0) && (result.force_x == 0) && (result.force_y == 0)
            && (result.force_z == 0) && !result.saturated)
        else $error("nonzero result for a pair beyond the cutoff");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (side_pipe_reg[14].valid && pipe_en) |=> side_pipe_reg[15].valid)
        else $error("word lost between the last two stages");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(pot15_reg) && $stable(side_pipe_reg[15]))
        else $error("last stage changed while held");

endmodule
